[design/dcfl_pkg.sv]
// Shared types and codes for the DER certificate field locator.
// Used by the front parser, the result queue, the output stage and the top level.
// No dependencies.
package dcfl_pkg;

	// Result kinds reported on the output channel
	localparam logic [2:0] KIND_SERIAL_HDR = 3'd0;
	localparam logic [2:0] KIND_SERIAL     = 3'd1;
	localparam logic [2:0] KIND_ISSUER     = 3'd2;
	localparam logic [2:0] KIND_VALIDITY   = 3'd3;
	localparam logic [2:0] KIND_SUBJECT    = 3'd4;
	localparam logic [2:0] KIND_KEY_INFO   = 3'd5;
	localparam logic [2:0] KIND_DONE       = 3'd6;
	localparam logic [2:0] KIND_FAIL       = 3'd7;

	// Configuration register indexes
	localparam logic CFG_IDX_FULL       = 1'b0;
	localparam logic CFG_IDX_SERIAL_HDR = 1'b1;

	// Parse phases
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_OUTER   = 4'd1;
	localparam logic [3:0] PH_TBS     = 4'd2;
	localparam logic [3:0] PH_FIRST   = 4'd3;
	localparam logic [3:0] PH_VERSION = 4'd4;
	localparam logic [3:0] PH_SERIAL  = 4'd5;
	localparam logic [3:0] PH_OID     = 4'd6;
	localparam logic [3:0] PH_ISSUER  = 4'd7;
	localparam logic [3:0] PH_VALID   = 4'd8;
	localparam logic [3:0] PH_SUBJECT = 4'd9;
	localparam logic [3:0] PH_KEY     = 4'd10;

	// Header steps
	localparam logic [1:0] ST_TAG  = 2'd0;
	localparam logic [1:0] ST_LEN  = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;
	localparam logic [1:0] ST_SKIP = 2'd3;

	// DER header constants
	localparam logic [7:0] LONG_FORM_BIT = 8'h80;
	localparam logic [7:0] VERSION_MASK  = 8'ha0;

	// Result queue depth (groups of results from one byte)
	localparam int QDEPTH = 4;

	// One result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic        last;
	} fld_t;

	// All results caused by one input byte (one to three)
	typedef struct packed {
		logic [1:0]      cnt;
		fld_t [2:0]      f;
	} grp_t;

	// Configuration register values
	typedef struct packed {
		logic want_full_fields;
		logic want_serial_with_header;
	} cfg_t;

endpackage

[design/dcfl_front.sv]
// Front parser: walks DER headers one byte per transaction and builds result groups.
// Depends on dcfl_pkg.
module dcfl_front #(
	parameter int POS_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            data_byte,
	input  logic                  first_byte,
	input  logic [15:0]           total_length,
	input  dcfl_pkg::cfg_t        cfg,
	output logic                  grp_we,
	output dcfl_pkg::grp_t        grp
);
	import dcfl_pkg::*;

	// Parser state
	logic [3:0]       phase_q;
	logic [1:0]       hstep_q;
	logic [31:0]      acc_q;
	logic [6:0]       lbl_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] hst_q;
	logic [31:0]      seqr_q;
	logic [31:0]      skipr_q;

	// Next-state values
	logic [3:0]       ph;
	logic [1:0]       hs;
	logic [31:0]      acc;
	logic [6:0]       lbl;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] hst;
	logic [31:0]      sr;
	logic [31:0]      skr;

	// Working values
	logic             run;
	logic             hdr;
	logic             fail;
	logic             done;
	logic             enter;
	logic [31:0]      hl;
	logic [POS_W-1:0] content;
	logic [POS_W-1:0] hlenp;
	logic [31:0]      whole;
	logic [1:0]       n;
	logic [POS_W+15:0] tl_x;
	logic [POS_W-1:0] tot;
	logic [POS_W+31:0] tot_x;
	logic [POS_W+31:0] hlen_x;
	logic [POS_W+15:0] hst_x;
	logic [POS_W+15:0] cnt_x;
	logic [15:0]      hst16;
	logic [15:0]      cnt16;

	// Byte parse, mirrors the header walk step by step
	always_comb begin
		ph      = phase_q;
		hs      = hstep_q;
		acc     = acc_q;
		lbl     = lbl_q;
		pos     = pos_q;
		hst     = hst_q;
		sr      = seqr_q;
		skr     = skipr_q;
		run     = 1'b0;
		hdr     = 1'b0;
		fail    = 1'b0;
		done    = 1'b0;
		enter   = 1'b0;
		hl      = 32'd0;
		n       = 2'd0;
		grp     = '0;
		tl_x    = {{POS_W{1'b0}}, total_length};
		tot     = tl_x[POS_W-1:0];
		tot_x   = {32'd0, tot};
		content = pos_q + {{(POS_W-1){1'b0}}, 1'b1};
		hlenp   = '0;
		hlen_x  = '0;
		whole   = 32'd0;
		hst_x   = '0;
		cnt_x   = {16'd0, content};
		cnt16   = cnt_x[15:0];
		hst16   = 16'd0;
		if (take) begin
			run = 1'b1;
			// restart on a first byte
			if (first_byte) begin
				ph  = PH_IDLE;
				hs  = ST_TAG;
				acc = 32'd0;
				lbl = 7'd0;
				pos = '0;
				hst = '0;
				skr = 32'd0;
				sr  = tot_x[31:0];
				if (tot == '0) begin
					grp.f[0] = '{kind: KIND_FAIL, offset: 16'd0, length: 16'd0, last: 1'b1};
					n   = 2'd1;
					run = 1'b0;
				end else begin
					ph = PH_OUTER;
				end
			end
			if (run && ph == PH_IDLE)
				run = 1'b0;
			if (run) begin
				content = pos + {{(POS_W-1){1'b0}}, 1'b1};
				cnt_x   = {16'd0, content};
				cnt16   = cnt_x[15:0];
				if (hs == ST_SKIP) begin
					skr = skr - 32'd1;
					if (skr == 32'd0)
						enter = 1'b1;
				end else begin
					sr = sr - 32'd1;
					if (hs == ST_TAG) begin
						if (ph == PH_FIRST)
							ph = ((data_byte & VERSION_MASK) == VERSION_MASK) ?
								PH_VERSION : PH_SERIAL;
						hst = pos;
						if (data_byte == 8'd0 || sr == 32'd0)
							fail = 1'b1;
						else
							hs = ST_LEN;
					end else if (hs == ST_LEN) begin
						if ((data_byte & LONG_FORM_BIT) != 8'd0) begin
							lbl = data_byte[6:0];
							acc = 32'd0;
							if (lbl == 7'd0) begin
								hdr = 1'b1;
								hl  = 32'd0;
							end else if (sr == 32'd0) begin
								fail = 1'b1;
							end else begin
								hs = ST_LONG;
							end
						end else begin
							hdr = 1'b1;
							hl  = {24'd0, data_byte};
						end
					end else begin
						acc = {acc[23:0], data_byte};
						lbl = lbl - 7'd1;
						if (lbl == 7'd0) begin
							hdr = 1'b1;
							hl  = acc;
						end else if (sr == 32'd0) begin
							fail = 1'b1;
						end
					end
				end
				// header complete: check length, report fields
				if (hdr) begin
					hlenp  = content - hst;
					hlen_x = {32'd0, hlenp};
					whole  = hlen_x[31:0] + hl;
					hst_x  = {16'd0, hst};
					hst16  = hst_x[15:0];
					if (hl > sr) begin
						fail = 1'b1;
					end else if (ph == PH_OUTER || ph == PH_TBS) begin
						sr    = hl;
						enter = 1'b1;
					end else begin
						case (ph)
							PH_SERIAL: begin
								if (cfg.want_serial_with_header) begin
									grp.f[n] = '{kind: KIND_SERIAL_HDR, offset: hst16,
										length: whole[15:0], last: 1'b0};
									n = n + 2'd1;
								end
								grp.f[n] = '{kind: KIND_SERIAL, offset: cnt16,
									length: hl[15:0], last: 1'b0};
								n = n + 2'd1;
							end
							PH_ISSUER: begin
								grp.f[n] = '{kind: KIND_ISSUER, offset: hst16,
									length: whole[15:0], last: 1'b0};
								n = n + 2'd1;
								if (!cfg.want_full_fields)
									done = 1'b1;
							end
							PH_VALID: begin
								grp.f[n] = '{kind: KIND_VALIDITY, offset: cnt16,
									length: hl[15:0], last: 1'b0};
								n = n + 2'd1;
							end
							PH_SUBJECT: begin
								grp.f[n] = '{kind: KIND_SUBJECT, offset: hst16,
									length: whole[15:0], last: 1'b0};
								n = n + 2'd1;
							end
							PH_KEY: begin
								grp.f[n] = '{kind: KIND_KEY_INFO, offset: hst16,
									length: whole[15:0], last: 1'b0};
								n    = n + 2'd1;
								done = 1'b1;
							end
							default: begin
							end
						endcase
						if (!done) begin
							sr  = sr - hl;
							skr = hl;
							if (hl == 32'd0)
								enter = 1'b1;
							else
								hs = ST_SKIP;
						end
					end
				end
				// move on to the next element of the enclosing sequence
				if (enter) begin
					ph = ph + 4'd1;
					hs = ST_TAG;
					if (sr == 32'd0)
						fail = 1'b1;
				end
				// end of certificate
				if (fail || done) begin
					grp.f[n] = '{kind: fail ? KIND_FAIL : KIND_DONE, offset: 16'd0,
						length: 16'd0, last: 1'b1};
					n  = n + 2'd1;
					ph = PH_IDLE;
					hs = ST_TAG;
				end
				pos = pos + {{(POS_W-1){1'b0}}, 1'b1};
			end
		end
		grp.cnt = n;
	end

	assign grp_we = take && (n != 2'd0);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hstep_q <= ST_TAG;
			acc_q   <= 32'd0;
			lbl_q   <= 7'd0;
			pos_q   <= '0;
			hst_q   <= '0;
			seqr_q  <= 32'd0;
			skipr_q <= 32'd0;
		end else begin
			phase_q <= ph;
			hstep_q <= hs;
			acc_q   <= acc;
			lbl_q   <= lbl;
			pos_q   <= pos;
			hst_q   <= hst;
			seqr_q  <= sr;
			skipr_q <= skr;
		end
	end

endmodule

[design/dcfl_queue.sv]
// Short queue of result groups between the parser and the output stage.
// Depends on dcfl_pkg.
module dcfl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  dcfl_pkg::grp_t wdata,
	input  logic           pop,
	output dcfl_pkg::grp_t rdata,
	output logic           empty,
	output logic           full
);
	import dcfl_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	grp_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(QDEPTH));
	assign rdata = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (we)
			mem_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (we)
				wr_ptr_q <= wr_ptr_q + {{(PW-1){1'b0}}, 1'b1};
			if (pop)
				rd_ptr_q <= rd_ptr_q + {{(PW-1){1'b0}}, 1'b1};
			if (we && !pop)
				cnt_q <= cnt_q + {{(CW-1){1'b0}}, 1'b1};
			else if (pop && !we)
				cnt_q <= cnt_q - {{(CW-1){1'b0}}, 1'b1};
		end
	end

endmodule

[design/dcfl_back.sv]
// Output stage: takes result groups from the queue and sends their results one per transaction.
// Depends on dcfl_pkg.
module dcfl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dcfl_pkg::grp_t q_rdata,
	output logic           q_pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata,
	output logic [2:0]     m_tuser,
	output logic           m_tlast
);
	import dcfl_pkg::*;

	grp_t       cur_q;
	logic [1:0] idx_q;
	logic       busy_q;

	logic fire;
	logic last_res;
	logic need_load;
	fld_t sel;

	assign fire      = busy_q && m_tready;
	assign last_res  = (idx_q == cur_q.cnt - 2'd1);
	assign need_load = !busy_q || (fire && last_res);
	assign q_pop     = need_load && !q_empty;

	// Present the current result
	assign sel      = cur_q.f[idx_q];
	assign m_tvalid = busy_q;
	assign m_tdata  = {sel.length, sel.offset};
	assign m_tuser  = sel.kind;
	assign m_tlast  = sel.last;

	// Group holding register, payload needs no reset
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_rdata;
	end

	// Result index and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 2'd0;
			busy_q <= 1'b0;
		end else if (q_pop) begin
			idx_q  <= 2'd0;
			busy_q <= 1'b1;
		end else if (fire) begin
			if (last_res)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

[design/der_cert_field_locator.sv]
// DER certificate field locator, top level.
// Holds the configuration registers and ties parser, result queue and output stage together.
// Depends on dcfl_pkg, dcfl_front, dcfl_queue, dcfl_back.
//
// Usage:
//   s_* carries the certificate one byte per transaction; tuser flags the first byte,
//   which restarts the parse and samples the certificate length from tdata.
//   m_* carries located fields: tuser is the field kind, tdata offset and length,
//   tlast closes the certificate on the done or failure result.
//   cfg_* writes the two mode registers; write only while the block is idle.
// Timing:
//   Bytes are taken one per cycle. A byte's results (up to three) leave one per cycle
//   while m_tready is high; their group is written into a four-group queue, then into
//   a holding register that presents it. The input stalls only when that queue is full,
//   i.e. after the receiver has held m_tready low long enough to back up four groups.
// Reset:
//   arst_n clears the parser to idle, empties the queue, drops m_tvalid and sets
//   both mode registers to 1. Bytes without the first-byte flag are ignored while idle.
module der_cert_field_locator #(
	parameter int CERT_LEN_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// bits: data_byte[7:0], total_length[23:8]
	input  logic [23:0] s_tdata,
	// bits: first_byte[0]
	input  logic        s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bits: field_offset[15:0], field_length[31:16]
	output logic [31:0] m_tdata,
	// bits: field_kind[2:0]
	output logic [2:0]  m_tuser,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic        cfg_wdata
);
	import dcfl_pkg::*;

	cfg_t cfg_q;
	logic take;
	logic grp_we;
	grp_t grp_w;
	grp_t grp_r;
	logic q_empty;
	logic q_full;
	logic q_pop;

	// Mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.want_full_fields        <= 1'b1;
			cfg_q.want_serial_with_header <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_IDX_FULL:       cfg_q.want_full_fields        <= cfg_wdata;
				CFG_IDX_SERIAL_HDR: cfg_q.want_serial_with_header <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	dcfl_front #(
		.POS_W(CERT_LEN_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (s_tdata[7:0]),
		.first_byte   (s_tuser),
		.total_length (s_tdata[23:8]),
		.cfg          (cfg_q),
		.grp_we       (grp_we),
		.grp          (grp_w)
	);

	dcfl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (grp_we),
		.wdata  (grp_w),
		.pop    (q_pop),
		.rdata  (grp_r),
		.empty  (q_empty),
		.full   (q_full)
	);

	dcfl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (grp_r),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
